[design/gmss_pkg.sv]
// Shared types, constants and helper functions for the G-code modal state scanner.
package gmss_pkg;

   localparam int VALUE_FRAC_DIGITS_DEFAULT = 3;
   localparam int CMD_FIFO_DEPTH_DEFAULT    = 2;

   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 80;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 3;
   localparam int CODE_W      = 10;
   localparam int SCALE_W     = 20;
   localparam int PRODUCT_W   = 32 + SCALE_W;

   localparam logic [CODE_W-1:0] CODE_MAX = 10'd1023;
   localparam logic [31:0]       MAG_MAX  = 32'h7FFF_FFFF;

   // character codes
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_OPEN     = 8'h28;
   localparam logic [7:0] CH_CLOSE    = 8'h29;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] CH_G        = 8'h47;
   localparam logic [7:0] CH_M        = 8'h4D;
   localparam logic [7:0] CH_F        = 8'h46;
   localparam logic [7:0] CH_S        = 8'h53;

   // G and M codes
   localparam logic [CODE_W-1:0] G_INCH        = 10'd20;
   localparam logic [CODE_W-1:0] G_MM          = 10'd21;
   localparam logic [CODE_W-1:0] G_ABS         = 10'd90;
   localparam logic [CODE_W-1:0] G_INC         = 10'd91;
   localparam logic [CODE_W-1:0] G_WCS_FIRST   = 10'd54;
   localparam logic [CODE_W-1:0] G_WCS_LAST    = 10'd59;
   localparam logic [CODE_W-1:0] M_SPIN_FIRST  = 10'd3;
   localparam logic [CODE_W-1:0] M_SPIN_LAST   = 10'd5;
   localparam logic [CODE_W-1:0] M_COOL_FIRST  = 10'd7;
   localparam logic [CODE_W-1:0] M_COOL_LAST   = 10'd9;

   localparam logic [2:0] OFFSET_MAX = 3'd5;
   localparam logic [1:0] STATE_OFF  = 2'd2;

   // reset values of the default registers
   localparam logic       RST_UNITS    = 1'b1;
   localparam logic [2:0] RST_OFFSET   = 3'd0;
   localparam logic       RST_DISTANCE = 1'b0;
   localparam logic [1:0] RST_SPINDLE  = 2'd2;
   localparam logic [1:0] RST_COOLANT  = 2'd2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_UNITS, CSR_OFFSET, CSR_DISTANCE, CSR_SPINDLE, CSR_COOLANT
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_CHAR, MODE_EOL, MODE_READ, MODE_CLEAR
   } mode_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_G_SP, PH_G_INT, PH_G_FRAC, PH_M_SP, PH_M_INT,
      PH_V_SP, PH_V_BODY, PH_V_TAIL, PH_O_SP, PH_O_NUM
   } phase_type;

   typedef enum logic [2:0] {
      LT_NONE, LT_G, LT_M, LT_F, LT_S, LT_OTHER
   } letter_type;

   typedef struct packed {
      mode_type   kind;
      logic [7:0] ch;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // acc * 10 + d, saturated to the largest positive magnitude
   function automatic logic [31:0] sat_mac(input logic [31:0] acc, input logic [3:0] d);
      logic [34:0] wide;
      wide = {acc, 3'b000} + {2'b00, acc, 1'b0} + {31'd0, d};
      sat_mac = (wide > {3'b000, MAG_MAX}) ? MAG_MAX : wide[31:0];
   endfunction

   // code * 10 + d, saturated at 1023
   function automatic logic [CODE_W-1:0] code_mac(input logic [CODE_W-1:0] acc,
                                                  input logic [3:0] d);
      logic [13:0] wide;
      wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {10'd0, d};
      code_mac = (wide > {4'd0, CODE_MAX}) ? CODE_MAX : wide[CODE_W-1:0];
   endfunction

   function automatic logic [SCALE_W-1:0] pow10(input logic [2:0] k);
      case (k)
         3'd0:    pow10 = 20'd1;
         3'd1:    pow10 = 20'd10;
         3'd2:    pow10 = 20'd100;
         3'd3:    pow10 = 20'd1000;
         3'd4:    pow10 = 20'd10000;
         3'd5:    pow10 = 20'd100000;
         3'd6:    pow10 = 20'd1000000;
         default: pow10 = 20'd1;
      endcase
   endfunction

endpackage

[design/gcode_modal_state_scanner_core.sv]
// Top level of the G-code modal state scanner.
//
// Usage:
//   req_* takes one transfer per program byte or command; req_tuser gives the
//   mode (character, end of line, read state, clear to defaults) and
//   req_tdata the character. Comments are stripped and letters folded in the
//   front end; words are scanned and the modal state kept in the back end.
//   Only a read produces a transfer on rsp_*, carrying units, work offset,
//   distance mode, spindle, coolant, feed and speed.
//   csr_* writes the default registers used by a clear; write only when idle.
// Timing:
//   One item per clock sustained while results are taken. A read's request
//   transfer writes the command queue; the result register is loaded when
//   the read leaves the queue head, and rsp_tvalid is registered with it.
//   The word scanner takes one byte per cycle while the queue is not empty;
//   value scaling at the end of an F or S word is a single multiply.
// Reset:
//   Scan and comment state cleared, default registers and modal state set to
//   G21, G54, G90, M5, M9, feed and speed zero. No clearing pass.
// Stall:
//   The result register holds while rsp_tready is low; the scanner stops at
//   the next read, the two-entry queue fills and req_tready then drops.
module gcode_modal_state_scanner_core #(
   parameter int VALUE_FRAC_DIGITS = gmss_pkg::VALUE_FRAC_DIGITS_DEFAULT,
   parameter int CMD_FIFO_DEPTH    = gmss_pkg::CMD_FIFO_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gmss_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [7:0] char_code
   input  logic [gmss_pkg::REQ_TUSER_W-1:0]   req_tuser,  // [1:0] mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] units, [3:1] work_offset, [4] distance_mode, [6:5] spindle_state,
   // [8:7] coolant_state, [40:9] feed_milli, [72:41] speed_milli,
   // [73] feed_is_set, [74] speed_is_set, [79:75] zero
   output logic [gmss_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_we,
   input  logic [gmss_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [gmss_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gmss_pkg::*;

   fifo_status_type fifo_status;
   cmd_type         push_cmd, head_cmd;
   logic            push, pop;

   gmss_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .fifo_status (fifo_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   gmss_cmd_fifo #(
      .DEPTH (CMD_FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (fifo_status)
   );

   gmss_back #(
      .VALUE_FRAC_DIGITS (VALUE_FRAC_DIGITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fifo_status (fifo_status),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

[design/gmss_front.sv]
// Front end: input transfers, comment stripping, case folding, command issue.
module gmss_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [gmss_pkg::REQ_TDATA_W-1:0]      req_tdata,  // [7:0] char_code
   input  logic [gmss_pkg::REQ_TUSER_W-1:0]      req_tuser,  // [1:0] mode
   input  gmss_pkg::fifo_status_type             fifo_status,
   output logic                                  push,
   output gmss_pkg::cmd_type                     push_cmd
);
   import gmss_pkg::*;

   logic in_paren_ff, in_paren_in;
   logic rest_comment_ff, rest_comment_in;
   logic accept;

   assign req_tready = !fifo_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_paren_in     = in_paren_ff;
      rest_comment_in = rest_comment_ff;
      push            = 1'b0;
      push_cmd.kind   = mode_type'(req_tuser);
      push_cmd.ch     = req_tdata;
      if (req_tdata >= CH_LOWER_A && req_tdata <= CH_LOWER_Z) begin
         push_cmd.ch = req_tdata - CASE_OFFSET;
      end
      if (accept) begin
         case (push_cmd.kind)
            MODE_CHAR: begin
               // ';' wins even inside parentheses
               if (rest_comment_ff) begin
                  push = 1'b0;
               end else if (req_tdata == CH_SEMI) begin
                  rest_comment_in = 1'b1;
               end else if (req_tdata == CH_OPEN) begin
                  in_paren_in = 1'b1;
               end else if (req_tdata == CH_CLOSE) begin
                  in_paren_in = 1'b0;
               end else if (!in_paren_ff) begin
                  push = 1'b1;
               end
            end
            MODE_EOL, MODE_CLEAR: begin
               push            = 1'b1;
               in_paren_in     = 1'b0;
               rest_comment_in = 1'b0;
            end
            MODE_READ: begin
               push = 1'b1;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_paren_ff     <= 1'b0;
         rest_comment_ff <= 1'b0;
      end else begin
         in_paren_ff     <= in_paren_in;
         rest_comment_ff <= rest_comment_in;
      end
   end

endmodule

[design/gmss_cmd_fifo.sv]
// Short command queue between the front end and the word scanner.
module gmss_cmd_fifo #(
   parameter int DEPTH = gmss_pkg::CMD_FIFO_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gmss_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output gmss_pkg::cmd_type          head_cmd,
   output gmss_pkg::fifo_status_type  status
);
   import gmss_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/gmss_back.sv]
// Back end: word scanner, modal state, default registers and result register.
module gmss_back #(
   parameter int VALUE_FRAC_DIGITS = gmss_pkg::VALUE_FRAC_DIGITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [gmss_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [gmss_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  gmss_pkg::fifo_status_type             fifo_status,
   input  gmss_pkg::cmd_type                     head_cmd,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] units, [3:1] work_offset, [4] distance_mode, [6:5] spindle_state,
   // [8:7] coolant_state, [40:9] feed_milli, [72:41] speed_milli,
   // [73] feed_is_set, [74] speed_is_set, [79:75] zero
   output logic [gmss_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);
   import gmss_pkg::*;

   localparam int FW = (VALUE_FRAC_DIGITS > 0) ? $clog2(VALUE_FRAC_DIGITS + 1) : 1;
   localparam logic [FW-1:0] FRAC_LIM = FW'(VALUE_FRAC_DIGITS);

   // default registers
   logic       dflt_units_ff;
   logic [2:0] dflt_offset_ff;
   logic       dflt_distance_ff;
   logic [1:0] dflt_spindle_ff;
   logic [1:0] dflt_coolant_ff;

   // word scan state
   phase_type        phase_ff, phase_in;
   letter_type       letter_ff, letter_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic             code_dig_ff, code_dig_in;
   logic [31:0]      val_ff, val_in;
   logic [FW-1:0]    frac_ff, frac_in;
   logic             dot_ff, dot_in;
   logic             neg_ff, neg_in;

   // modal state
   logic       units_ff, units_in;
   logic [2:0] offset_ff, offset_in;
   logic       distance_ff, distance_in;
   logic [1:0] spindle_ff, spindle_in;
   logic [1:0] coolant_ff, coolant_in;
   logic [31:0] feed_ff, feed_in;
   logic [31:0] speed_ff, speed_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic                   rsp_load;

   logic [7:0]  c;
   logic [3:0]  d;
   logic        is_digit, is_dot, is_num, is_sign, is_space, is_blank;
   logic [31:0] vc_val;
   logic [FW-1:0] vc_frac;
   logic        vc_dot, vc_tail;
   logic [2:0]  scale_k;
   logic [PRODUCT_W-1:0] product;
   logic [31:0] mag, signed_val;
   logic        finish, consumed;
   logic        feed_pos, speed_pos;

   assign c        = head_cmd.ch;
   assign d        = c[3:0];
   assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_dot   = (c == CH_DOT);
   assign is_num   = is_digit || is_dot;
   assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
   assign is_space = (c == CH_SPACE);
   assign is_blank = is_space || ((c >= CH_TAB) && (c <= CH_CR));

   assign pop = !fifo_status.empty &&
                ((head_cmd.kind != MODE_READ) || !rsp_valid_ff || rsp_tready);

   // one digit or dot of an F or S value
   always_comb begin
      vc_val  = val_ff;
      vc_frac = frac_ff;
      vc_dot  = dot_ff;
      vc_tail = 1'b0;
      if (is_digit) begin
         if (!dot_ff) begin
            vc_val = sat_mac(val_ff, d);
         end else if (frac_ff < FRAC_LIM) begin
            vc_val  = sat_mac(val_ff, d);
            vc_frac = frac_ff + FW'(1);
         end
      end else if (dot_ff) begin
         vc_tail = 1'b1;
      end else begin
         vc_dot = 1'b1;
      end
   end

   // scale missing fraction digits in one multiply; saturation is monotone
   assign scale_k    = 3'(VALUE_FRAC_DIGITS) - 3'(frac_ff);
   assign product    = val_ff * pow10(scale_k);
   assign mag        = (product > PRODUCT_W'(MAG_MAX)) ? MAG_MAX : product[31:0];
   assign signed_val = neg_ff ? (32'd0 - mag) : mag;

   always_comb begin
      phase_in    = phase_ff;
      letter_in   = letter_ff;
      code_in     = code_ff;
      code_dig_in = code_dig_ff;
      val_in      = val_ff;
      frac_in     = frac_ff;
      dot_in      = dot_ff;
      neg_in      = neg_ff;
      units_in    = units_ff;
      offset_in   = offset_ff;
      distance_in = distance_ff;
      spindle_in  = spindle_ff;
      coolant_in  = coolant_ff;
      feed_in     = feed_ff;
      speed_in    = speed_ff;
      finish      = 1'b0;
      consumed    = 1'b0;
      rsp_load    = 1'b0;

      if (pop) begin
         case (head_cmd.kind)
            MODE_CHAR: begin
               case (phase_ff)
                  PH_G_SP, PH_G_INT: begin
                     if (is_space && phase_ff == PH_G_SP) begin
                        consumed = 1'b1;
                     end else if (is_digit) begin
                        code_in     = code_mac(code_ff, d);
                        code_dig_in = 1'b1;
                        phase_in    = PH_G_INT;
                        consumed    = 1'b1;
                     end else if (is_dot) begin
                        phase_in = PH_G_FRAC;
                        consumed = 1'b1;
                     end
                  end
                  PH_G_FRAC: begin
                     consumed = is_digit;
                  end
                  PH_M_SP, PH_M_INT: begin
                     if (is_space && phase_ff == PH_M_SP) begin
                        consumed = 1'b1;
                     end else if (is_digit) begin
                        code_in     = code_mac(code_ff, d);
                        code_dig_in = 1'b1;
                        phase_in    = PH_M_INT;
                        consumed    = 1'b1;
                     end
                  end
                  PH_V_SP: begin
                     if (is_space) begin
                        consumed = 1'b1;
                     end else if (is_sign) begin
                        neg_in   = (c == CH_MINUS);
                        phase_in = PH_V_BODY;
                        consumed = 1'b1;
                     end else if (is_num) begin
                        val_in   = vc_val;
                        frac_in  = vc_frac;
                        dot_in   = vc_dot;
                        phase_in = PH_V_BODY;
                        consumed = 1'b1;
                     end
                  end
                  PH_V_BODY: begin
                     if (is_num) begin
                        val_in   = vc_val;
                        frac_in  = vc_frac;
                        dot_in   = vc_dot;
                        phase_in = vc_tail ? PH_V_TAIL : PH_V_BODY;
                        consumed = 1'b1;
                     end
                  end
                  PH_V_TAIL, PH_O_NUM: begin
                     consumed = is_num;
                  end
                  PH_O_SP: begin
                     if (is_space) begin
                        consumed = 1'b1;
                     end else if (is_sign || is_num) begin
                        phase_in = PH_O_NUM;
                        consumed = 1'b1;
                     end
                  end
                  default: begin
                     consumed = 1'b0;
                  end
               endcase

               // byte ends the word (or none was open) and is read between words
               if (!consumed) begin
                  finish      = 1'b1;
                  phase_in    = PH_IDLE;
                  letter_in   = LT_NONE;
                  code_in     = '0;
                  code_dig_in = 1'b0;
                  val_in      = '0;
                  frac_in     = '0;
                  dot_in      = 1'b0;
                  neg_in      = 1'b0;
                  if (!is_blank) begin
                     if (c == CH_G) begin
                        letter_in = LT_G;
                        phase_in  = PH_G_SP;
                     end else if (c == CH_M) begin
                        letter_in = LT_M;
                        phase_in  = PH_M_SP;
                     end else if (c == CH_F) begin
                        letter_in = LT_F;
                        phase_in  = PH_V_SP;
                     end else if (c == CH_S) begin
                        letter_in = LT_S;
                        phase_in  = PH_V_SP;
                     end else begin
                        letter_in = LT_OTHER;
                        phase_in  = PH_O_SP;
                     end
                  end
               end
            end
            MODE_EOL, MODE_CLEAR: begin
               finish      = (head_cmd.kind == MODE_EOL);
               phase_in    = PH_IDLE;
               letter_in   = LT_NONE;
               code_in     = '0;
               code_dig_in = 1'b0;
               val_in      = '0;
               frac_in     = '0;
               dot_in      = 1'b0;
               neg_in      = 1'b0;
            end
            MODE_READ: begin
               rsp_load = 1'b1;
            end
            default: begin
               rsp_load = 1'b0;
            end
         endcase
      end

      // effect of the word just ended, from the state it left
      if (finish) begin
         case (phase_ff)
            PH_G_INT, PH_G_FRAC: begin
               if (code_dig_ff) begin
                  if (code_ff == G_INCH) begin
                     units_in = 1'b0;
                  end else if (code_ff == G_MM) begin
                     units_in = 1'b1;
                  end else if (code_ff == G_ABS) begin
                     distance_in = 1'b0;
                  end else if (code_ff == G_INC) begin
                     distance_in = 1'b1;
                  end else if (code_ff >= G_WCS_FIRST && code_ff <= G_WCS_LAST) begin
                     offset_in = 3'(code_ff - G_WCS_FIRST);
                  end
               end
            end
            PH_M_INT: begin
               if (code_ff >= M_SPIN_FIRST && code_ff <= M_SPIN_LAST) begin
                  spindle_in = 2'(code_ff - M_SPIN_FIRST);
               end else if (code_ff >= M_COOL_FIRST && code_ff <= M_COOL_LAST) begin
                  coolant_in = 2'(code_ff - M_COOL_FIRST);
               end
            end
            PH_V_BODY, PH_V_TAIL: begin
               if (letter_ff == LT_F) begin
                  feed_in = signed_val;
               end else if (letter_ff == LT_S) begin
                  speed_in = signed_val;
               end
            end
            default: begin
               finish = 1'b1;
            end
         endcase
      end

      if (pop && head_cmd.kind == MODE_CLEAR) begin
         units_in    = dflt_units_ff;
         offset_in   = (dflt_offset_ff > OFFSET_MAX) ? OFFSET_MAX : dflt_offset_ff;
         distance_in = dflt_distance_ff;
         spindle_in  = (dflt_spindle_ff > STATE_OFF) ? STATE_OFF : dflt_spindle_ff;
         coolant_in  = (dflt_coolant_ff > STATE_OFF) ? STATE_OFF : dflt_coolant_ff;
         feed_in     = '0;
         speed_in    = '0;
      end
   end

   assign feed_pos     = (feed_ff != 32'd0) && !feed_ff[31];
   assign speed_pos    = (speed_ff != 32'd0) && !speed_ff[31];
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_units_ff    <= RST_UNITS;
         dflt_offset_ff   <= RST_OFFSET;
         dflt_distance_ff <= RST_DISTANCE;
         dflt_spindle_ff  <= RST_SPINDLE;
         dflt_coolant_ff  <= RST_COOLANT;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_UNITS:    dflt_units_ff    <= csr_wdata[0];
            CSR_OFFSET:   dflt_offset_ff   <= csr_wdata[2:0];
            CSR_DISTANCE: dflt_distance_ff <= csr_wdata[0];
            CSR_SPINDLE:  dflt_spindle_ff  <= csr_wdata[1:0];
            CSR_COOLANT:  dflt_coolant_ff  <= csr_wdata[1:0];
            default: begin
               dflt_units_ff <= dflt_units_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         letter_ff    <= LT_NONE;
         code_ff      <= '0;
         code_dig_ff  <= 1'b0;
         val_ff       <= '0;
         frac_ff      <= '0;
         dot_ff       <= 1'b0;
         neg_ff       <= 1'b0;
         units_ff     <= RST_UNITS;
         offset_ff    <= RST_OFFSET;
         distance_ff  <= RST_DISTANCE;
         spindle_ff   <= RST_SPINDLE;
         coolant_ff   <= RST_COOLANT;
         feed_ff      <= '0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         letter_ff    <= letter_in;
         code_ff      <= code_in;
         code_dig_ff  <= code_dig_in;
         val_ff       <= val_in;
         frac_ff      <= frac_in;
         dot_ff       <= dot_in;
         neg_ff       <= neg_in;
         units_ff     <= units_in;
         offset_ff    <= offset_in;
         distance_ff  <= distance_in;
         spindle_ff   <= spindle_in;
         coolant_ff   <= coolant_in;
         feed_ff      <= feed_in;
         speed_ff     <= speed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {5'd0, speed_pos, feed_pos, speed_ff, feed_ff, coolant_ff,
                         spindle_ff, distance_ff, offset_ff, units_ff};
      end
   end

   a_read_shows: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("read popped but no result registered");

   a_modal_range: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= OFFSET_MAX && spindle_ff <= STATE_OFF && coolant_ff <= STATE_OFF)
      else $error("modal state out of range");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      !val_ff[31] && frac_ff <= FRAC_LIM)
      else $error("value accumulator out of range");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> (code_ff == '0 && val_ff == '0 && !dot_ff && !neg_ff))
      else $error("word fields left over while idle");

   a_eol_idle: assert property (@(posedge clock) disable iff (reset)
      (pop && head_cmd.kind == MODE_EOL) |=> phase_ff == PH_IDLE)
      else $error("word still open after end of line");

endmodule

[tb/tb.sv]
// Self-checking testbench for the G-code modal state scanner core.
`timescale 1ns / 100ps

module tb;
   import gmss_pkg::*;

   localparam int FRAC_DIGITS  = VALUE_FRAC_DIGITS_DEFAULT;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_ITEMS  = 330;
   // index that decodes to no register
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic        units;
      logic [2:0]  offset;
      logic        distance;
      logic [1:0]  spindle;
      logic [1:0]  coolant;
      logic [31:0] feed;
      logic [31:0] speed;
      logic        feed_set;
      logic        speed_set;
   } modal_snapshot_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   bit                 idle_on        = 1'b1;
   int unsigned        sent_count     = 0;
   int unsigned        mismatch_count = 0;
   int unsigned        quiet_cycles   = 0;
   modal_snapshot_type expected_states[$];
   logic [7:0]         line_text[$];

   // scanner state as the block should hold it
   phase_type   scan_phase;
   letter_type  scan_letter;
   bit          in_paren, line_comment;
   logic [9:0]  code_acc;
   bit          code_seen;
   logic [31:0] mag_acc;
   int unsigned frac_count;
   bit          dot_seen, neg_value;
   logic        units_q, dist_q;
   logic [2:0]  offset_q;
   logic [1:0]  spindle_q, coolant_q;
   logic [31:0] feed_q, speed_q;
   logic        dflt_units, dflt_distance;
   logic [2:0]  dflt_offset;
   logic [1:0]  dflt_spindle, dflt_coolant;

   gcode_modal_state_scanner_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] mag_step(input logic [31:0] acc, input logic [3:0] d);
      logic [63:0] wide;
      wide = {32'd0, acc} * 64'd10 + {60'd0, d};
      return (wide > {32'd0, MAG_MAX}) ? MAG_MAX : wide[31:0];
   endfunction

   function automatic logic [9:0] code_step(input logic [9:0] acc, input logic [3:0] d);
      logic [31:0] wide;
      wide = {22'd0, acc} * 32'd10 + {28'd0, d};
      return (wide > 32'd1023) ? CODE_MAX : wide[CODE_W-1:0];
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic void drop_word();
      scan_phase  = PH_IDLE;
      scan_letter = LT_NONE;
      code_acc    = '0;
      code_seen   = 1'b0;
      mag_acc     = '0;
      frac_count  = 0;
      dot_seen    = 1'b0;
      neg_value   = 1'b0;
   endfunction

   function automatic void drop_scan();
      drop_word();
      in_paren     = 1'b0;
      line_comment = 1'b0;
   endfunction

   function automatic void load_modal_defaults();
      units_q   = dflt_units;
      offset_q  = (dflt_offset > OFFSET_MAX) ? OFFSET_MAX : dflt_offset;
      dist_q    = dflt_distance;
      spindle_q = (dflt_spindle > STATE_OFF) ? STATE_OFF : dflt_spindle;
      coolant_q = (dflt_coolant > STATE_OFF) ? STATE_OFF : dflt_coolant;
      feed_q    = '0;
      speed_q   = '0;
   endfunction

   function automatic void reset_predictor();
      dflt_units    = RST_UNITS;
      dflt_offset   = RST_OFFSET;
      dflt_distance = RST_DISTANCE;
      dflt_spindle  = RST_SPINDLE;
      dflt_coolant  = RST_COOLANT;
      drop_scan();
      load_modal_defaults();
   endfunction

   function automatic void add_code(input logic [7:0] c);
      code_acc  = code_step(code_acc, c[3:0]);
      code_seen = 1'b1;
   endfunction

   // scale to thousandths, then apply the sign
   function automatic void commit_number();
      logic [31:0] mag, v;
      int unsigned k;
      mag = mag_acc;
      for (k = frac_count; k < FRAC_DIGITS; k++)
         mag = mag_step(mag, 4'd0);
      v = neg_value ? (32'd0 - mag) : mag;
      if (scan_letter == LT_F)
         feed_q = v;
      else if (scan_letter == LT_S)
         speed_q = v;
   endfunction

   function automatic void end_word();
      case (scan_phase)
         PH_G_INT, PH_G_FRAC: begin
            if (code_seen) begin
               if (code_acc == G_INCH)
                  units_q = 1'b0;
               else if (code_acc == G_MM)
                  units_q = 1'b1;
               else if (code_acc == G_ABS)
                  dist_q = 1'b0;
               else if (code_acc == G_INC)
                  dist_q = 1'b1;
               else if (code_acc >= G_WCS_FIRST && code_acc <= G_WCS_LAST)
                  offset_q = 3'(code_acc - G_WCS_FIRST);
            end
         end
         PH_M_INT: begin
            if (code_acc >= M_SPIN_FIRST && code_acc <= M_SPIN_LAST)
               spindle_q = 2'(code_acc - M_SPIN_FIRST);
            else if (code_acc >= M_COOL_FIRST && code_acc <= M_COOL_LAST)
               coolant_q = 2'(code_acc - M_COOL_FIRST);
         end
         PH_V_BODY, PH_V_TAIL: commit_number();
         default: ;
      endcase
      drop_word();
   endfunction

   function automatic void number_char(input logic [7:0] c);
      if (is_digit(c)) begin
         if (!dot_seen) begin
            mag_acc = mag_step(mag_acc, c[3:0]);
         end else if (frac_count < FRAC_DIGITS) begin
            mag_acc = mag_step(mag_acc, c[3:0]);
            frac_count++;
         end
      end else if (dot_seen) begin
         scan_phase = PH_V_TAIL;   // second dot closes the value
      end else begin
         dot_seen = 1'b1;
      end
   endfunction

   // 1 when the byte belongs to the word in progress
   function automatic bit word_takes(input logic [7:0] c);
      bit digit, num, sign;
      digit = is_digit(c);
      num   = digit || c == CH_DOT;
      sign  = c == CH_PLUS || c == CH_MINUS;
      case (scan_phase)
         PH_G_SP: begin
            if (c == CH_SPACE)
               return 1'b1;
            if (digit) begin
               add_code(c);
               scan_phase = PH_G_INT;
               return 1'b1;
            end
            if (c == CH_DOT) begin
               scan_phase = PH_G_FRAC;
               return 1'b1;
            end
            return 1'b0;
         end
         PH_G_INT: begin
            if (digit) begin
               add_code(c);
               return 1'b1;
            end
            if (c == CH_DOT) begin
               scan_phase = PH_G_FRAC;
               return 1'b1;
            end
            return 1'b0;
         end
         PH_G_FRAC: return digit;
         PH_M_SP: begin
            if (c == CH_SPACE)
               return 1'b1;
            if (digit) begin
               add_code(c);
               scan_phase = PH_M_INT;
               return 1'b1;
            end
            return 1'b0;
         end
         PH_M_INT: begin
            if (digit) begin
               add_code(c);
               return 1'b1;
            end
            return 1'b0;
         end
         PH_V_SP: begin
            if (c == CH_SPACE)
               return 1'b1;
            if (sign) begin
               neg_value  = (c == CH_MINUS);
               scan_phase = PH_V_BODY;
               return 1'b1;
            end
            if (num) begin
               scan_phase = PH_V_BODY;
               number_char(c);
               return 1'b1;
            end
            return 1'b0;
         end
         PH_V_BODY: begin
            if (num) begin
               number_char(c);
               return 1'b1;
            end
            return 1'b0;
         end
         PH_V_TAIL: return num;
         PH_O_SP: begin
            if (c == CH_SPACE)
               return 1'b1;
            if (sign || num) begin
               scan_phase = PH_O_NUM;
               return 1'b1;
            end
            return 1'b0;
         end
         PH_O_NUM: return num;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void scan_byte(input logic [7:0] c);
      if (scan_phase != PH_IDLE) begin
         if (word_takes(c))
            return;
         end_word();
      end
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
         return;
      if (c == CH_G) begin
         scan_letter = LT_G;
         scan_phase  = PH_G_SP;
      end else if (c == CH_M) begin
         scan_letter = LT_M;
         scan_phase  = PH_M_SP;
      end else if (c == CH_F) begin
         scan_letter = LT_F;
         scan_phase  = PH_V_SP;
      end else if (c == CH_S) begin
         scan_letter = LT_S;
         scan_phase  = PH_V_SP;
      end else begin
         scan_letter = LT_OTHER;
         scan_phase  = PH_O_SP;
      end
   endfunction

   function automatic void predict_item(input mode_type kind, input logic [7:0] c);
      logic [7:0] b;
      modal_snapshot_type snap;
      b = c;
      case (kind)
         MODE_CHAR: begin
            if (line_comment) begin
            end else if (b == CH_SEMI) begin
               line_comment = 1'b1;
            end else if (b == CH_OPEN) begin
               in_paren = 1'b1;
            end else if (b == CH_CLOSE) begin
               in_paren = 1'b0;
            end else if (!in_paren) begin
               if (b >= CH_LOWER_A && b <= CH_LOWER_Z)
                  b = b - CASE_OFFSET;
               scan_byte(b);
            end
         end
         MODE_EOL: begin
            end_word();
            drop_scan();
         end
         MODE_CLEAR: begin
            drop_scan();
            load_modal_defaults();
         end
         default: begin
            snap.units     = units_q;
            snap.offset    = offset_q;
            snap.distance  = dist_q;
            snap.spindle   = spindle_q;
            snap.coolant   = coolant_q;
            snap.feed      = feed_q;
            snap.speed     = speed_q;
            snap.feed_set  = (feed_q != 32'd0) && !feed_q[31];
            snap.speed_set = (speed_q != 32'd0) && !speed_q[31];
            expected_states = {expected_states, snap};
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_results
      modal_snapshot_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.units     = rsp_tdata[0];
         got.offset    = rsp_tdata[3:1];
         got.distance  = rsp_tdata[4];
         got.spindle   = rsp_tdata[6:5];
         got.coolant   = rsp_tdata[8:7];
         got.feed      = rsp_tdata[40:9];
         got.speed     = rsp_tdata[72:41];
         got.feed_set  = rsp_tdata[73];
         got.speed_set = rsp_tdata[74];
         if (expected_states.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected state transfer: %h", rsp_tdata);
         end else begin
            want = expected_states.pop_front();
            compare_field("units", 32'(want.units), 32'(got.units));
            compare_field("work_offset", 32'(want.offset), 32'(got.offset));
            compare_field("distance_mode", 32'(want.distance), 32'(got.distance));
            compare_field("spindle_state", 32'(want.spindle), 32'(got.spindle));
            compare_field("coolant_state", 32'(want.coolant), 32'(got.coolant));
            compare_field("feed_milli", want.feed, got.feed);
            compare_field("speed_milli", want.speed, got.speed);
            compare_field("feed_is_set", 32'(want.feed_set), 32'(got.feed_set));
            compare_field("speed_is_set", 32'(want.speed_set), 32'(got.speed_set));
         end
      end
   end

   // result side back-pressure
   always @(posedge clock)
      rsp_tready <= idle_on ? ($urandom_range(99) >= 9) : 1'b1;

   // ends the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(255));
   endfunction

   task automatic send_item(input mode_type kind, input logic [7:0] ch);
      if (idle_on && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < 9);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= ch;
      do
         @(posedge clock);
      while (!req_tready);
      sent_count++;
      predict_item(kind, ch);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(MODE_CHAR, s[i]);
   endtask

   // stop sending and let everything in flight come out
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_states.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [2:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_UNITS:    dflt_units    = v[0];
         CSR_OFFSET:   dflt_offset   = v;
         CSR_DISTANCE: dflt_distance = v[0];
         CSR_SPINDLE:  dflt_spindle  = v[1:0];
         CSR_COOLANT:  dflt_coolant  = v[1:0];
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- program text

   function automatic void put(input logic [7:0] c);
      line_text = {line_text, c};
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         put(s[i]);
   endfunction

   function automatic void put_letter(input logic [7:0] upper);
      put(($urandom_range(3) == 0) ? upper + CASE_OFFSET : upper);
   endfunction

   function automatic void put_digits(input int unsigned n);
      for (int i = 0; i < n; i++)
         put(CH_ZERO + 8'($urandom_range(9)));
   endfunction

   function automatic void put_sign();
      put($urandom_range(1) ? CH_MINUS : CH_PLUS);
   endfunction

   function automatic void put_printable(input int unsigned n);
      for (int i = 0; i < n; i++)
         put(8'($urandom_range(126, 32)));
   endfunction

   // separator between words; sometimes none at all
   function automatic void put_gap();
      int unsigned r;
      r = $urandom_range(9);
      if (r >= 3 && r <= 7) begin
         put(CH_SPACE);
      end else if (r == 8) begin
         put(CH_TAB);
      end else if (r == 9) begin
         put(CH_SPACE);
         put(CH_SPACE);
      end
   endfunction

   // spaces after the letter; a tab here ends the word
   function automatic void put_pad();
      case ($urandom_range(7))
         0: put(CH_SPACE);
         1: begin
            put(CH_SPACE);
            put(CH_SPACE);
         end
         2: put(CH_TAB);
         default: ;
      endcase
   endfunction

   function automatic int unsigned pick_code(input bit g_word);
      int unsigned r;
      r = $urandom_range(9);
      if (r < 5) begin
         if (!g_word)
            return $urandom_range(10, 2);
         case ($urandom_range(4))
            0: return 20 + $urandom_range(1);
            1: return 90 + $urandom_range(1);
            2, 3: return 54 + $urandom_range(5);
            default: return $urandom_range(1) ? 53 : 60;
         endcase
      end
      if (r < 8)
         return $urandom_range(99);
      if (r == 8)
         return $urandom_range(99999, 1024);
      // would alias onto a live code without saturation
      return 1024 + $urandom_range(100);
   endfunction

   function automatic void gen_g_word();
      put_letter(CH_G);
      put_pad();
      if ($urandom_range(9) != 0) begin
         if ($urandom_range(9) == 0)
            put(CH_ZERO);
         put_text($sformatf("%0d", pick_code(1'b1)));
         if ($urandom_range(4) == 0) begin
            put(CH_DOT);
            put_digits($urandom_range(2));
         end
      end else if ($urandom_range(1)) begin
         put(CH_DOT);
         put_digits($urandom_range(2));
      end
   endfunction

   function automatic void gen_m_word();
      put_letter(CH_M);
      put_pad();
      if ($urandom_range(9) != 0)
         put_text($sformatf("%0d", pick_code(1'b0)));
      if ($urandom_range(9) == 0)
         put_text(".5");
   endfunction

   function automatic void gen_value_word(input logic [7:0] letter);
      int unsigned r;
      put_letter(letter);
      put_pad();
      r = $urandom_range(9);
      if (r == 0) begin
         put_sign();
      end else if (r == 1) begin
         put(CH_DOT);
         if ($urandom_range(1))
            put(CH_DOT);
      end else begin
         if ($urandom_range(2) == 0)
            put_sign();
         if ($urandom_range(5) == 0)
            put_digits($urandom_range(12, 10));   // saturates
         else
            put_digits($urandom_range(4));
         if ($urandom_range(9) < 7) begin
            put(CH_DOT);
            put_digits($urandom_range(6));
            if ($urandom_range(9) == 0) begin
               put(CH_DOT);
               put_digits($urandom_range(2));
            end
         end
      end
   endfunction

   function automatic void gen_other_word();
      put_letter(8'h41 + 8'($urandom_range(25)));
      put_pad();
      case ($urandom_range(5))
         0: put_text("0x1F");
         1: put_text("1.5e3");
         2: put_text("inf");
         3: put_text("-nan");
         default: begin
            if ($urandom_range(1))
               put_sign();
            put_digits($urandom_range(4));
            if ($urandom_range(1)) begin
               put(CH_DOT);
               put_digits($urandom_range(3));
            end
         end
      endcase
   endfunction

   function automatic void gen_paren_comment();
      put(CH_OPEN);
      put_printable($urandom_range(6));
      if ($urandom_range(4) != 0)
         put(CH_CLOSE);
   endfunction

   function automatic void build_line();
      int unsigned words, r;
      line_text.delete();
      words = $urandom_range(6, 1);
      for (int w = 0; w < words; w++) begin
         put_gap();
         r = $urandom_range(99);
         if (r < 25) begin
            gen_g_word();
         end else if (r < 40) begin
            gen_m_word();
         end else if (r < 55) begin
            gen_value_word(CH_F);
         end else if (r < 70) begin
            gen_value_word(CH_S);
         end else if (r < 82) begin
            gen_other_word();
         end else if (r < 90) begin
            gen_paren_comment();
         end else if (r < 95) begin
            put(any_byte());
         end else begin
            put(CH_SEMI);
            put_printable($urandom_range(4));
            break;
         end
      end
   endfunction

   task automatic send_random_line();
      int unsigned r;
      build_line();
      foreach (line_text[i]) begin
         r = $urandom_range(199);
         if (r < 4)
            send_item(MODE_READ, any_byte());
         else if (r == 4)
            send_item(MODE_CLEAR, any_byte());
         send_item(MODE_CHAR, line_text[i]);
      end
      if ($urandom_range(9) != 0)
         send_item(MODE_EOL, any_byte());
      if ($urandom_range(9) < 7)
         send_item(MODE_READ, any_byte());
   endtask

   // ---------------------------------------------------------------- tests

   // saturation, truncation, mid-line read, byte extremes, comments, clear
   task automatic test_directed_program();
      send_text("G1044f-1.23456");
      send_item(MODE_READ, 8'hFF);
      send_item(MODE_EOL, 8'h00);
      send_item(MODE_READ, any_byte());
      send_item(MODE_CHAR, 8'hFF);
      send_item(MODE_CHAR, 8'h00);
      send_text("s(x)5;M3");
      send_item(MODE_EOL, any_byte());
      send_item(MODE_READ, any_byte());
      send_item(MODE_CLEAR, any_byte());
      send_item(MODE_READ, any_byte());
   endtask

   task automatic test_default_registers(input logic [2:0] u, input logic [2:0] o,
                                         input logic [2:0] d, input logic [2:0] sp,
                                         input logic [2:0] co, input bit touch_spare);
      settle();
      write_reg(CSR_UNITS, u);
      write_reg(CSR_OFFSET, o);
      write_reg(CSR_DISTANCE, d);
      write_reg(CSR_SPINDLE, sp);
      write_reg(CSR_COOLANT, co);
      if (touch_spare)
         write_reg(CSR_SPARE, 3'($urandom_range(7)));
      @(posedge clock);
      csr_we <= 1'b0;
      send_item(MODE_CLEAR, any_byte());
      send_item(MODE_READ, any_byte());
   endtask

   task automatic test_random_program(input int unsigned goal, input bit with_idling);
      int unsigned start;
      idle_on = with_idling;
      start   = sent_count;
      while (sent_count - start < goal)
         send_random_line();
   endtask

   initial begin
      reset_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_program();
      test_default_registers(3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 1'b1);
      test_random_program(PHASE_ITEMS, 1'b1);
      test_default_registers(3'd1, 3'd5, 3'd1, 3'd2, 3'd2, 1'b0);
      test_random_program(PHASE_ITEMS, 1'b0);
      // out of range defaults clamp on clear
      test_default_registers(3'd0, 3'd7, 3'd1, 3'd3, 3'd3, 1'b0);
      test_random_program(PHASE_ITEMS, 1'b1);
      test_default_registers(3'($urandom_range(7)), 3'($urandom_range(7)),
                             3'($urandom_range(7)), 3'($urandom_range(7)),
                             3'($urandom_range(7)), 1'b0);
      test_random_program(PHASE_ITEMS, 1'b1);

      settle();
      if (mismatch_count == 0 && expected_states.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
